// File: src/bda_pkg.sv
// Shared constants and helper function of the binary to decimal ASCII converter.
package bda_pkg;

	// Width of the value field on the input channel.
	localparam int VALUE_W = 64;

	// Default number of significant value bits.
	localparam int VALUE_BITS_DEF = 64;

	// Width of one packed decimal digit and of one output character.
	localparam int DIGIT_W = 4;
	localparam int CHAR_W = 6;

	// ASCII code of the character '0'.
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	// Number of decimal digits needed for any value of the given bit width.
	// The factor 30103/100000 approximates log10(2) from above, which is
	// never an exact integer multiple for a positive width.
	function automatic int bda_num_digits(input int bits);
		return (bits * 30103) / 100000 + 1;
	endfunction

endpackage

// File: src/bda_convert.sv
// Bit-serial shift-and-add-three converter from binary to packed decimal digits.
module bda_convert #(
	parameter int VALUE_BITS = bda_pkg::VALUE_BITS_DEF,
	parameter int NUM_DIGITS = bda_pkg::bda_num_digits(VALUE_BITS)
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [VALUE_BITS-1:0]                   value,
	output logic                                    bcd_valid,
	input  logic                                    bcd_ready,
	output logic [NUM_DIGITS*bda_pkg::DIGIT_W-1:0]  bcd
);
	import bda_pkg::*;

	localparam int BCD_W = NUM_DIGITS * DIGIT_W;
	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_DONE
	} conv_state_t;

	conv_state_t        state_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [BCD_W-1:0]   bcd_adj;

	// Add three to every digit of five or more before the next doubling.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3;
			end else begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	// Sequencer: load the value, shift one bit per cycle, then hand off the digits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			val_q   <= '0;
			bcd_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						val_q   <= value;
						bcd_q   <= '0;
						cnt_q   <= CNT_W'(VALUE_BITS);
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					bcd_q <= {bcd_adj[BCD_W-2:0], val_q[VALUE_BITS-1]};
					val_q <= val_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (bcd_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign bcd_valid = (state_q == ST_DONE);
	assign bcd       = bcd_q;

endmodule

// File: src/bda_emit.sv
// Digit emitter: skips leading zeros and sends one ASCII character per beat.
module bda_emit #(
	parameter int NUM_DIGITS = bda_pkg::bda_num_digits(bda_pkg::VALUE_BITS_DEF)
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    bcd_valid,
	output logic                                    bcd_ready,
	input  logic [NUM_DIGITS*bda_pkg::DIGIT_W-1:0]  bcd,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [bda_pkg::CHAR_W-1:0]              digit_char,
	output logic                                    last
);
	import bda_pkg::*;

	localparam int BCD_W = NUM_DIGITS * DIGIT_W;
	localparam int REM_W = $clog2(NUM_DIGITS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SKIP,
		ST_EMIT
	} emit_state_t;

	emit_state_t        state_q;
	logic [BCD_W-1:0]   dig_q;
	logic [REM_W-1:0]   rem_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  digit_char_q;
	logic               last_q;
	logic [DIGIT_W-1:0] top_digit;
	logic               slot_free;
	logic               load_char;

	assign top_digit = dig_q[BCD_W-1 -: DIGIT_W];
	assign slot_free = !out_valid_q || out_ready;
	assign load_char = (state_q == ST_EMIT) && slot_free;

	// Sequencer with the output register: one digit leaves the top per cycle unless the output stalls the emit state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dig_q        <= '0;
			rem_q        <= '0;
			out_valid_q  <= 1'b0;
			digit_char_q <= ASCII_ZERO;
			last_q       <= 1'b0;
		end else begin
			// A loaded character refills the output register and takes priority over emptying it.
			if (load_char) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (bcd_valid) begin
						dig_q   <= bcd;
						rem_q   <= REM_W'(NUM_DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// Drop leading zeros, but always keep the final digit.
					if (top_digit == '0 && rem_q != REM_W'(1)) begin
						dig_q <= dig_q << DIGIT_W;
						rem_q <= rem_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						digit_char_q <= ASCII_ZERO + CHAR_W'(top_digit);
						last_q       <= (rem_q == REM_W'(1));
						dig_q        <= dig_q << DIGIT_W;
						rem_q        <= rem_q - 1'b1;
						if (rem_q == REM_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign bcd_ready  = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign digit_char = digit_char_q;
	assign last       = last_q;

endmodule

// File: src/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter.
// Each input beat carries an unsigned number, of which the low VALUE_BITS bits are used; the
// block returns its decimal digits as ASCII characters, most significant first, without
// leading zeros, one character per output beat, with last set on the final digit (zero gives
// a single '0'). The converter shifts the value through a shift-and-add-three digit register
// one bit per cycle. The emitter then drops one leading zero per cycle and sends one character
// per cycle while the output is not stalled. Both parts run concurrently on successive numbers:
// the converter takes the next number while the emitter still sends the digits of the last one.
module binary_to_decimal_ascii #(
	parameter int VALUE_BITS = bda_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bda_pkg::VALUE_W-1:0]  value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bda_pkg::CHAR_W-1:0]   digit_char,
	output logic                         last
);
	import bda_pkg::*;

	localparam int NUM_DIGITS = bda_num_digits(VALUE_BITS);

	logic                          bcd_valid;
	logic                          bcd_ready;
	logic [NUM_DIGITS*DIGIT_W-1:0] bcd;

	// Binary to packed decimal conversion.
	bda_convert #(
		.VALUE_BITS (VALUE_BITS),
		.NUM_DIGITS (NUM_DIGITS)
	) u_convert (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value[VALUE_BITS-1:0]),
		.bcd_valid (bcd_valid),
		.bcd_ready (bcd_ready),
		.bcd       (bcd)
	);

	// Character output.
	bda_emit #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.bcd_valid  (bcd_valid),
		.bcd_ready  (bcd_ready),
		.bcd        (bcd),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit_char (digit_char),
		.last       (last)
	);

endmodule

// File: src/bda_checker.sv
// Port-level assertions for the binary to decimal ASCII converter, bound to the top level.
module bda_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [bda_pkg::CHAR_W-1:0]  digit_char,
	input logic                        last
);
	import bda_pkg::*;

	// A stalled output beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat withdrawn while stalled");

	// A stalled output beat keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(digit_char) && $stable(last))
		else $error("output payload changed while stalled");

	// Every character offered is a decimal digit.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + 6'd9))
		else $error("output character is not a decimal digit");

	// The converter works on one number at a time and is busy after accepting one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while conversion in progress");

endmodule

bind binary_to_decimal_ascii bda_checker u_bda_checker (.*);
